// ===== rtl/cpmp_pkg.sv =====
// Package for the character property modifier parser: item types, opcodes
// and the operand length decode. No dependencies.
`default_nettype none

package cpmp_pkg;

    // Opcodes and masks
    localparam logic [15:0] OP_BOLD    = 16'h0835;
    localparam logic [15:0] OP_ITALIC  = 16'h0836;
    localparam logic [15:0] OP_SIZE    = 16'h4A43;
    localparam logic [15:0] OP_TABS    = 16'hC615;
    localparam logic [15:0] CLASS_MASK = 16'hE000;
    localparam logic [15:0] CLASS_VAR  = 16'hC000;
    localparam logic [7:0]  TABS_EXT   = 8'd255;

    // Operand codes for the flag toggles
    localparam logic [7:0] TOG_CLEAR  = 8'h00;
    localparam logic [7:0] TOG_SET    = 8'h01;
    localparam logic [7:0] TOG_INVERT = 8'h81;

    // Class codes (opcode bits 15..13)
    localparam logic [2:0] CLS_0 = 3'd0;
    localparam logic [2:0] CLS_1 = 3'd1;
    localparam logic [2:0] CLS_2 = 3'd2;
    localparam logic [2:0] CLS_3 = 3'd3;
    localparam logic [2:0] CLS_4 = 3'd4;
    localparam logic [2:0] CLS_5 = 3'd5;
    localparam logic [2:0] CLS_7 = 3'd7;

    localparam int          POS_W      = 11;
    localparam logic [15:0] SIZE_RESET = 16'd20;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        start_bold;
        logic        start_italic;
        logic [15:0] start_font_size;
    } in_item_t;

    typedef struct packed {
        logic        bold;
        logic        italic;
        logic [15:0] font_size;
    } out_item_t;

    // Total modifier length from the opcode class; 0 for the variable class
    function automatic pos_t fixed_length(input logic [15:0] op);
        pos_t len;
        case (op[15:13])
            CLS_0, CLS_1:        len = pos_t'(3);
            CLS_2, CLS_4, CLS_5: len = pos_t'(4);
            CLS_7:               len = pos_t'(5);
            CLS_3:               len = pos_t'(6);
            default:             len = '0;
        endcase
        return len;
    endfunction

    // Flag update from an operand byte
    function automatic logic apply_toggle(input logic flag, input logic [7:0] code);
        logic res;
        case (code)
            TOG_CLEAR:  res = 1'b0;
            TOG_SET:    res = 1'b1;
            TOG_INVERT: res = ~flag;
            default:    res = flag;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpmp_parser.sv =====
// Parser state and the per-byte update for the modifier list.
// Depends on cpmp_pkg.
`default_nettype none

module cpmp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire cpmp_pkg::in_item_t item,
    output cpmp_pkg::out_item_t     result
);

    logic [15:0]    opcode_word_reg, opcode_word_next;
    cpmp_pkg::pos_t byte_position_reg, byte_position_next;
    cpmp_pkg::pos_t modifier_length_reg, modifier_length_next;
    logic [7:0]     delete_count_reg, delete_count_next;
    logic [7:0]     low_operand_byte_reg, low_operand_byte_next;
    logic           bold_flag_reg, bold_flag_next;
    logic           italic_flag_reg, italic_flag_next;
    logic [15:0]    size_value_reg, size_value_next;

    cpmp_pkg::pos_t pos;
    logic           var_class;
    logic [11:0]    pos_inc;

    // Next state for one byte
    always_comb
    begin
        opcode_word_next      = opcode_word_reg;
        pos                   = byte_position_reg;
        modifier_length_next  = modifier_length_reg;
        delete_count_next     = delete_count_reg;
        low_operand_byte_next = low_operand_byte_reg;
        bold_flag_next        = bold_flag_reg;
        italic_flag_next      = italic_flag_reg;
        size_value_next       = size_value_reg;
        var_class             = 1'b0;

        if (item.first_byte)
        begin
            bold_flag_next       = item.start_bold;
            italic_flag_next     = item.start_italic;
            size_value_next      = item.start_font_size;
            pos                  = '0;
            modifier_length_next = '0;
            delete_count_next    = '0;
        end

        if (pos == cpmp_pkg::pos_t'(0))
        begin
            opcode_word_next     = {8'h00, item.data_byte};
            modifier_length_next = '0;
        end
        else if (pos == cpmp_pkg::pos_t'(1))
        begin
            opcode_word_next     = {item.data_byte, opcode_word_reg[7:0]};
            modifier_length_next = cpmp_pkg::fixed_length(opcode_word_next);
        end
        else
        begin
            var_class = (opcode_word_reg & cpmp_pkg::CLASS_MASK) == cpmp_pkg::CLASS_VAR;
            if (pos == cpmp_pkg::pos_t'(2))
            begin
                if (opcode_word_reg == cpmp_pkg::OP_BOLD)
                    bold_flag_next = cpmp_pkg::apply_toggle(bold_flag_next, item.data_byte);
                else if (opcode_word_reg == cpmp_pkg::OP_ITALIC)
                    italic_flag_next = cpmp_pkg::apply_toggle(italic_flag_next,
                                                              item.data_byte);
                else if (opcode_word_reg == cpmp_pkg::OP_SIZE)
                    low_operand_byte_next = item.data_byte;
                if (var_class)
                begin
                    if (opcode_word_reg == cpmp_pkg::OP_TABS &&
                        item.data_byte == cpmp_pkg::TABS_EXT)
                        modifier_length_next = '0;
                    else
                        modifier_length_next = cpmp_pkg::pos_t'(3) + {3'b000, item.data_byte};
                end
            end
            else if (pos == cpmp_pkg::pos_t'(3) && opcode_word_reg == cpmp_pkg::OP_SIZE)
            begin
                size_value_next = {item.data_byte, low_operand_byte_reg};
            end
            else if (modifier_length_next == '0 && pos == cpmp_pkg::pos_t'(3))
            begin
                delete_count_next = item.data_byte;
            end
            else if (modifier_length_next == '0 &&
                     pos == cpmp_pkg::pos_t'(4) + {1'b0, delete_count_next, 2'b00})
            begin
                // tab list: 5 + 4*del + 3*add
                modifier_length_next = cpmp_pkg::pos_t'(5) + {1'b0, delete_count_next, 2'b00}
                                     + {2'b00, item.data_byte, 1'b0}
                                     + {3'b000, item.data_byte};
            end
        end

        // Advance within the modifier, wrap at its end
        pos_inc = {1'b0, pos} + 12'd1;
        if (modifier_length_next != '0 && pos_inc >= {1'b0, modifier_length_next})
            byte_position_next = '0;
        else
            byte_position_next = pos_inc[cpmp_pkg::POS_W-1:0];

        if (item.last_byte)
        begin
            byte_position_next   = '0;
            modifier_length_next = '0;
        end
    end

    // Values after this byte, taken by the result register on a last byte
    assign result.bold      = bold_flag_next;
    assign result.italic    = italic_flag_next;
    assign result.font_size = size_value_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_word_reg      <= '0;
            byte_position_reg    <= '0;
            modifier_length_reg  <= '0;
            delete_count_reg     <= '0;
            low_operand_byte_reg <= '0;
            bold_flag_reg        <= 1'b0;
            italic_flag_reg      <= 1'b0;
            size_value_reg       <= cpmp_pkg::SIZE_RESET;
        end
        else if (step)
        begin
            opcode_word_reg      <= opcode_word_next;
            byte_position_reg    <= byte_position_next;
            modifier_length_reg  <= modifier_length_next;
            delete_count_reg     <= delete_count_next;
            low_operand_byte_reg <= low_operand_byte_next;
            bold_flag_reg        <= bold_flag_next;
            italic_flag_reg      <= italic_flag_next;
            size_value_reg       <= size_value_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/character_property_modifier_parser_top.sv =====
// Top level of the character property modifier parser: input register,
// parser core and result register. Depends on cpmp_pkg and cpmp_parser.
//
// The block takes a character property modifier list one byte per item and
// returns the final bold, italic and font size once, for the item marked
// last_byte. It sustains one byte per cycle unless a last byte is held for a
// pending result: each byte passes an input register and is parsed by the
// state update in cpmp_parser, and on a last byte the result is registered in
// the output register, from which result_valid is driven. Bytes that are
// not last keep flowing while a result waits to be taken; only a second
// last byte waits for the pending result to leave.
`default_nettype none

module character_property_modifier_parser_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               data_valid,
    output logic                    data_ready,
    input  wire cpmp_pkg::in_item_t data,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output cpmp_pkg::out_item_t     result
);

    logic                in_valid_reg;
    cpmp_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    cpmp_pkg::out_item_t out_item_reg;
    cpmp_pkg::out_item_t parsed;
    logic                step;
    logic                out_free;

    // Parse the held byte when its result, if any, has room
    assign out_free   = !out_valid_reg || result_ready;
    assign step       = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign data_ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (data_ready)
            in_valid_reg <= data_valid;
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
            in_item_reg <= data;
    end

    cpmp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (parsed)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && in_item_reg.last_byte)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_item_reg.last_byte)
            out_item_reg <= parsed;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

// ===== tb/character_property_modifier_parser_top_tb.sv =====
// Testbench for character_property_modifier_parser_top: sends byte lists of
// character property modifiers and checks the bold, italic and size results
// against a parser model kept in a scoreboard. Depends on cpmp_pkg and the top level.
`default_nettype none

module character_property_modifier_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1650;
    localparam int CYCLE_LIMIT = 400000;

    // Tracks the parser state and the character properties still to come
    class char_props_scoreboard;
        cpmp_pkg::out_item_t expected_props[$];
        int unsigned         mismatches;

        logic [15:0]    opcode;
        cpmp_pkg::pos_t pos;
        cpmp_pkg::pos_t mod_len;
        logic [7:0]     del_cnt;
        logic [7:0]     size_lo;
        logic           bold_f;
        logic           italic_f;
        logic [15:0]    size_f;

        function new();
            mismatches = 0;
            opcode     = '0;
            pos        = '0;
            mod_len    = '0;
            del_cnt    = '0;
            size_lo    = '0;
            bold_f     = 1'b0;
            italic_f   = 1'b0;
            size_f     = cpmp_pkg::SIZE_RESET;
        endfunction

        // Bytes in a modifier (opcode included); 0 while the length byte is due
        function cpmp_pkg::pos_t operand_span(input logic [15:0] op);
            logic [2:0] cls;
            cls = op[15:13];
            if (cls == cpmp_pkg::CLS_0 || cls == cpmp_pkg::CLS_1)
                return cpmp_pkg::pos_t'(3);
            if (cls == cpmp_pkg::CLS_2 || cls == cpmp_pkg::CLS_4 || cls == cpmp_pkg::CLS_5)
                return cpmp_pkg::pos_t'(4);
            if (cls == cpmp_pkg::CLS_3)
                return cpmp_pkg::pos_t'(6);
            if (cls == cpmp_pkg::CLS_7)
                return cpmp_pkg::pos_t'(5);
            return cpmp_pkg::pos_t'(0);
        endfunction

        function logic toggled(input logic flag, input logic [7:0] code);
            if (code == cpmp_pkg::TOG_CLEAR)
                return 1'b0;
            if (code == cpmp_pkg::TOG_SET)
                return 1'b1;
            if (code == cpmp_pkg::TOG_INVERT)
                return !flag;
            return flag;
        endfunction

        function int pending();
            return expected_props.size();
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(input cpmp_pkg::in_item_t it);
            int                  p;
            logic [7:0]          b;
            cpmp_pkg::out_item_t props;
            b = it.data_byte;
            if (it.first_byte)
            begin
                bold_f   = it.start_bold;
                italic_f = it.start_italic;
                size_f   = it.start_font_size;
                pos      = '0;
                mod_len  = '0;
                del_cnt  = '0;
            end
            p = int'(pos);
            if (p == 0)
            begin
                opcode  = {8'h00, b};
                mod_len = '0;
            end
            else if (p == 1)
            begin
                opcode[15:8] = b;
                mod_len      = operand_span(opcode);
            end
            else if (p == 2)
            begin
                if (opcode == cpmp_pkg::OP_BOLD)
                    bold_f = toggled(bold_f, b);
                else if (opcode == cpmp_pkg::OP_ITALIC)
                    italic_f = toggled(italic_f, b);
                else if (opcode == cpmp_pkg::OP_SIZE)
                    size_lo = b;
                if ((opcode & cpmp_pkg::CLASS_MASK) == cpmp_pkg::CLASS_VAR)
                begin
                    if (opcode == cpmp_pkg::OP_TABS && b == cpmp_pkg::TABS_EXT)
                        mod_len = '0;
                    else
                        mod_len = cpmp_pkg::pos_t'(3 + int'(b));
                end
            end
            else if (p == 3 && opcode == cpmp_pkg::OP_SIZE)
                size_f = {b, size_lo};
            else if (mod_len == 0 && p == 3)
                del_cnt = b;
            else if (mod_len == 0 && p == 4 + 4 * int'(del_cnt))
                mod_len = cpmp_pkg::pos_t'(5 + 4 * int'(del_cnt) + 3 * int'(b));

            // Wrap to the next modifier once this one is complete
            if (mod_len != 0 && p + 1 >= int'(mod_len))
                pos = '0;
            else
                pos = cpmp_pkg::pos_t'(p + 1);

            if (it.last_byte)
            begin
                props.bold      = bold_f;
                props.italic    = italic_f;
                props.font_size = size_f;
                expected_props.insert(expected_props.size(), props);
                pos     = '0;
                mod_len = '0;
            end
        endfunction

        // Compare one delivered result with the oldest expectation
        function void check_props(input cpmp_pkg::out_item_t got);
            cpmp_pkg::out_item_t want;
            if (expected_props.size() == 0)
            begin
                $display("%0t: unexpected result bold=%0b italic=%0b size=%0d",
                         $realtime, got.bold, got.italic, got.font_size);
                mismatches++;
                return;
            end
            want = expected_props.pop_front();
            if (got.bold !== want.bold)
            begin
                $display("%0t: bold expected %0b got %0b", $realtime, want.bold, got.bold);
                mismatches++;
            end
            if (got.italic !== want.italic)
            begin
                $display("%0t: italic expected %0b got %0b",
                         $realtime, want.italic, got.italic);
                mismatches++;
            end
            if (got.font_size !== want.font_size)
            begin
                $display("%0t: font_size expected %0d got %0d",
                         $realtime, want.font_size, got.font_size);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                data_valid;
    logic                data_ready;
    cpmp_pkg::in_item_t  data;
    logic                result_valid;
    logic                result_ready;
    cpmp_pkg::out_item_t result;

    char_props_scoreboard props_sb;
    logic [7:0]           list_bytes[$];
    bit                   sender_calm;
    int                   bytes_sent;
    int                   cycle_count;

    character_property_modifier_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data         (data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Monitors: note accepted bytes, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && data_valid && data_ready)
            props_sb.note_byte(data);
        if (rst_n && result_valid && result_ready)
            props_sb.check_props(result);
    end

    // Send one byte, idling first unless in a calm stretch
    task automatic drive_byte(input cpmp_pkg::in_item_t it);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data       <= it;
        @(posedge clk);
        while (!data_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Send the current byte list; start values matter on the first byte only
    task automatic send_list(input bit mark_first, input bit mark_last,
                             input logic st_bold, input logic st_italic,
                             input logic [15:0] st_size);
        cpmp_pkg::in_item_t it;
        for (int i = 0; i < list_bytes.size(); i++)
        begin
            it.data_byte       = list_bytes[i];
            it.first_byte      = mark_first && (i == 0);
            it.last_byte       = mark_last && (i == list_bytes.size() - 1);
            it.start_bold      = (i == 0) ? st_bold : 1'($urandom_range(0, 1));
            it.start_italic    = (i == 0) ? st_italic : 1'($urandom_range(0, 1));
            it.start_font_size = (i == 0) ? st_size : 16'($urandom_range(0, 65535));
            drive_byte(it);
        end
    endtask

    // Append one byte to the list under construction
    function automatic void append_byte(input logic [7:0] b);
        list_bytes.insert(list_bytes.size(), b);
    endfunction

    function automatic void push_rand(input int n);
        for (int i = 0; i < n; i++)
            append_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_op(input logic [15:0] op);
        append_byte(op[7:0]);
        append_byte(op[15:8]);
    endfunction

    // Count for variable-length parts: mostly short, now and then long
    function automatic int span_count(input int rare_max);
        if ($urandom_range(0, 30) == 0)
            return $urandom_range(0, rare_max);
        return $urandom_range(0, 3);
    endfunction

    // Append one well-formed modifier with random content
    function automatic void add_modifier();
        logic [15:0] op;
        int          n;
        int          dels;
        int          adds;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                push_op($urandom_range(0, 1) ? cpmp_pkg::OP_BOLD : cpmp_pkg::OP_ITALIC);
                case ($urandom_range(0, 4))
                    0:       append_byte(cpmp_pkg::TOG_CLEAR);
                    1:       append_byte(cpmp_pkg::TOG_SET);
                    2:       append_byte(8'h80);
                    3:       append_byte(cpmp_pkg::TOG_INVERT);
                    default: push_rand(1);
                endcase
            end
            3, 4:
            begin
                push_op(cpmp_pkg::OP_SIZE);
                push_rand(2);
            end
            5:
            begin
                // any fixed-length class
                op = 16'($urandom_range(0, 65535));
                if ((op & cpmp_pkg::CLASS_MASK) == cpmp_pkg::CLASS_VAR)
                    op[13] = 1'b1;
                push_op(op);
                push_rand(int'(props_sb.operand_span(op)) - 2);
            end
            6:
            begin
                // variable class with a length byte
                op = 16'($urandom_range(0, 65535));
                op = (op & ~cpmp_pkg::CLASS_MASK) | cpmp_pkg::CLASS_VAR;
                if (op == cpmp_pkg::OP_TABS)
                    op[0] = ~op[0];
                n = span_count(255);
                push_op(op);
                append_byte(8'(n));
                push_rand(n);
            end
            7:
            begin
                // tab modifier in its plain length form
                n = $urandom_range(0, 6);
                push_op(cpmp_pkg::OP_TABS);
                append_byte(8'(n));
                push_rand(n);
            end
            default:
            begin
                // tab modifier with delete and add counts
                dels = span_count(40);
                adds = span_count(40);
                push_op(cpmp_pkg::OP_TABS);
                append_byte(cpmp_pkg::TABS_EXT);
                append_byte(8'(dels));
                push_rand(4 * dels);
                append_byte(8'(adds));
                push_rand(3 * adds);
            end
        endcase
    endfunction

    // Mostly well-formed lists; some truncated, padded, or pure noise
    function automatic void build_random_list();
        list_bytes.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            push_rand($urandom_range(1, 8));
            return;
        end
        repeat ($urandom_range(1, 5)) add_modifier();
        case ($urandom_range(0, 19))
            0:
            begin
                repeat ($urandom_range(1, 2))
                    if (list_bytes.size() > 1)
                        void'(list_bytes.pop_back());
            end
            1:       push_rand(1);
            default: ;
        endcase
    endfunction

    // Result side: ready idles at random, with calm stretches
    initial
    begin
        int gap;
        bit calm;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    // Reset, directed lists, random lists, drain
    initial
    begin
        props_sb     = new();
        bytes_sent   = 0;
        sender_calm  = 1'b0;
        rst_n        <= 1'b0;
        data_valid   <= 1'b0;
        data         <= '0;
        result_ready <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // set bold, invert italic
        list_bytes = {8'h35, 8'h08, cpmp_pkg::TOG_SET, 8'h36, 8'h08, cpmp_pkg::TOG_INVERT};
        send_list(1'b1, 1'b1, 1'b0, 1'b1, 16'h0000);
        // largest font size
        list_bytes = {8'h43, 8'h4A, 8'hFF, 8'hFF};
        send_list(1'b1, 1'b1, 1'b1, 1'b0, 16'h1234);
        // first and last on one byte: start values come back
        list_bytes = {8'h35};
        send_list(1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
        // no first mark, size with only its low byte
        list_bytes = {8'h43, 8'h4A, 8'h12};
        send_list(1'b0, 1'b1, 1'b0, 1'b0, 16'h0000);
        // tab modifier with counts, then bold left as it is
        list_bytes = {8'h15, 8'hC6, cpmp_pkg::TABS_EXT, 8'h00, 8'h01, 8'hAA, 8'hBB,
                      8'hCC, 8'h35, 8'h08, 8'h80};
        send_list(1'b1, 1'b1, 1'b1, 1'b0, cpmp_pkg::SIZE_RESET);

        // random lists
        while (bytes_sent < BYTE_TARGET)
        begin
            sender_calm = ($urandom_range(0, 4) == 0);
            build_random_list();
            send_list($urandom_range(0, 19) != 0, $urandom_range(0, 12) != 0,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)));
        end
        data_valid <= 1'b0;

        while (props_sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (props_sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
